[hw/rtl/lms_pkg.sv]
// Shared types, field widths, phase codes and helpers for the LIN master
// schedule sequencer. No dependencies; imported by every module of the block.
`default_nettype none

package lms_pkg;

  localparam int MAX_SLOTS      = 4;
  localparam int MAX_DATA_BYTES = 8;

  localparam int SLOT_W   = $clog2(MAX_SLOTS);
  localparam int DATA_W   = 64;
  localparam int ENTRY_W  = 16;
  localparam int STATUS_W = 2;
  localparam int PHASE_W  = 3;
  localparam int LEN_W    = 4;
  localparam int SCNT_W   = 3;
  localparam int WAIT_W   = 16;
  localparam int CIDX_W   = 3;

  // Stream payload widths, padded to whole bytes
  localparam int IN_FIELDS_W  = STATUS_W + DATA_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + 8 + 1 + 1 + LEN_W + DATA_W + PHASE_W + SLOT_W
                                + 1 + DATA_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_SEND       = 3'd0;
  localparam logic [PHASE_W-1:0] PH_TX_WAIT    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_RX_WAIT    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_TX_OK      = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RX_OK      = 3'd4;
  localparam logic [PHASE_W-1:0] PH_TX_TIMEOUT = 3'd5;
  localparam logic [PHASE_W-1:0] PH_RX_TIMEOUT = 3'd6;

  // Driver status codes
  localparam logic [STATUS_W-1:0] ST_TX_OK = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RX_OK = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_SCHEDULE_TABLE = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SLOT_COUNT     = 3'd1;
  localparam logic [CIDX_W-1:0] REG_TX_PAYLOAD     = 3'd2;
  localparam logic [CIDX_W-1:0] REG_TX_WAIT_LIMIT  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_RX_WAIT_LIMIT  = 3'd4;

  // Configuration reset values
  localparam logic [DATA_W-1:0] RST_SCHEDULE_TABLE = 64'd0;
  localparam logic [SCNT_W-1:0] RST_SLOT_COUNT     = 3'd2;
  localparam logic [DATA_W-1:0] RST_TX_PAYLOAD     = 64'h0706_0504_0302_0100;
  localparam logic [WAIT_W-1:0] RST_WAIT_LIMIT     = 16'd10;

  localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

  typedef struct packed {
    logic [DATA_W-1:0] schedule_table;
    logic [SCNT_W-1:0] slot_count;
    logic [DATA_W-1:0] tx_payload;
    logic [WAIT_W-1:0] tx_wait_limit;
    logic [WAIT_W-1:0] rx_wait_limit;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0]  received_data;
    logic               received_valid;
    logic [SLOT_W-1:0]  slot;
    logic [PHASE_W-1:0] phase;
    logic [DATA_W-1:0]  send_data;
    logic [LEN_W-1:0]   send_length;
    logic               send_receive;
    logic               send_enhanced;
    logic [7:0]         send_pid;
    logic               send_valid;
  } result_t;

  // Keep the first len bytes of v, zero the rest
  function automatic logic [DATA_W-1:0] first_bytes(input logic [DATA_W-1:0] v,
                                                    input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] r;
    r = '0;
    for (int b = 0; b < DATA_W / 8; b++) begin
      if (LEN_W'(b) < len) r[b*8 +: 8] = v[b*8 +: 8];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/lms_cfg_regs.sv]
// Configuration register file for the LIN master schedule sequencer.
// Depends on lms_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module lms_cfg_regs (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire  [lms_pkg::CIDX_W-1:0]  cfg_index,
  input  wire  [lms_pkg::DATA_W-1:0]  cfg_data,
  output lms_pkg::cfg_t               cfg
);
  import lms_pkg::*;

  logic wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  // Write the addressed register on a transaction; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.schedule_table <= RST_SCHEDULE_TABLE;
      cfg.slot_count     <= RST_SLOT_COUNT;
      cfg.tx_payload     <= RST_TX_PAYLOAD;
      cfg.tx_wait_limit  <= RST_WAIT_LIMIT;
      cfg.rx_wait_limit  <= RST_WAIT_LIMIT;
    end else if (wr) begin
      case (cfg_index)
        REG_SCHEDULE_TABLE: cfg.schedule_table <= cfg_data;
        REG_SLOT_COUNT:     cfg.slot_count     <= cfg_data[SCNT_W-1:0];
        REG_TX_PAYLOAD:     cfg.tx_payload     <= cfg_data;
        REG_TX_WAIT_LIMIT:  cfg.tx_wait_limit  <= cfg_data[WAIT_W-1:0];
        REG_RX_WAIT_LIMIT:  cfg.rx_wait_limit  <= cfg_data[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lms_step.sv]
// Sequencer state (phase, slot, wait counters) and the one-tick step logic.
// Depends on lms_pkg for phase codes, status codes, cfg_t and result_t.
`default_nettype none

module lms_step (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          advance,
  input  wire  [lms_pkg::STATUS_W-1:0] status,
  input  wire  [lms_pkg::DATA_W-1:0]   ddata,
  input  lms_pkg::cfg_t                cfg,
  output lms_pkg::result_t             res
);
  import lms_pkg::*;

  logic [PHASE_W-1:0] phase_reg, phase_reg_next;
  logic [SLOT_W-1:0]  slot_index, slot_index_next;
  logic [WAIT_W-1:0]  tx_wait_count, tx_wait_count_next;
  logic [WAIT_W-1:0]  rx_wait_count, rx_wait_count_next;

  logic [ENTRY_W-1:0] entry;
  logic [LEN_W-1:0]   len;
  logic [SCNT_W-1:0]  slot_limit;
  logic [SCNT_W-1:0]  slot_inc;

  // Current slot entry, length clamped to the frame maximum
  assign entry = cfg.schedule_table[{slot_index, 4'd0} +: ENTRY_W];
  assign len   = (entry[13:10] > LEN_W'(MAX_DATA_BYTES)) ? LEN_W'(MAX_DATA_BYTES)
                                                         : entry[13:10];

  // Slot count above the table size acts as the table size
  assign slot_limit = (cfg.slot_count > SCNT_W'(MAX_SLOTS)) ? SCNT_W'(MAX_SLOTS)
                                                            : cfg.slot_count;
  assign slot_inc   = {1'b0, slot_index} + SCNT_W'(1);

  always_comb begin
    phase_reg_next     = phase_reg;
    slot_index_next    = slot_index;
    tx_wait_count_next = tx_wait_count;
    rx_wait_count_next = rx_wait_count;
    res                = '0;
    case (phase_reg)
      PH_SEND: begin
        tx_wait_count_next = '0;
        rx_wait_count_next = '0;
        res.send_valid     = 1'b1;
        res.send_pid       = entry[7:0];
        res.send_enhanced  = entry[8];
        res.send_receive   = entry[9];
        res.send_length    = len;
        if (!entry[9]) begin
          res.send_data  = first_bytes(cfg.tx_payload, len);
          phase_reg_next = PH_TX_WAIT;
        end else begin
          phase_reg_next = PH_RX_WAIT;
        end
      end
      PH_TX_WAIT: begin
        if (status == ST_TX_OK) phase_reg_next = PH_TX_OK;
        else if (tx_wait_count != WAIT_MAX) tx_wait_count_next = tx_wait_count + WAIT_W'(1);
        // Timeout wins over success
        if (tx_wait_count_next >= cfg.tx_wait_limit) phase_reg_next = PH_TX_TIMEOUT;
      end
      PH_RX_WAIT: begin
        if (status == ST_RX_OK) begin
          res.received_valid = 1'b1;
          res.received_data  = first_bytes(ddata, len);
          phase_reg_next     = PH_RX_OK;
        end else if (rx_wait_count != WAIT_MAX) begin
          rx_wait_count_next = rx_wait_count + WAIT_W'(1);
        end
        if (rx_wait_count_next >= cfg.rx_wait_limit) phase_reg_next = PH_RX_TIMEOUT;
      end
      PH_TX_OK, PH_RX_OK, PH_TX_TIMEOUT, PH_RX_TIMEOUT: begin
        phase_reg_next  = PH_SEND;
        slot_index_next = (slot_inc >= slot_limit) ? '0 : slot_inc[SLOT_W-1:0];
      end
      default: phase_reg_next = PH_SEND;
    endcase
    res.phase = phase_reg_next;
    res.slot  = slot_index_next;
  end

  // Commit the step when the tick moves on to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_SEND;
      slot_index    <= '0;
      tx_wait_count <= '0;
      rx_wait_count <= '0;
    end else if (advance) begin
      phase_reg     <= phase_reg_next;
      slot_index    <= slot_index_next;
      tx_wait_count <= tx_wait_count_next;
      rx_wait_count <= rx_wait_count_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lin_master_schedule_sequencer.sv]
// LIN master schedule sequencer: usage notes
// Slave channel s_*: one transaction per scheduler tick carrying the driver
// status and received bytes. Master channel m_*: one result transaction per
// tick with the frame request, new phase, slot and received bytes.
// Config channel cfg_*: register index and 64-bit data, always ready; write
// only while no tick is in flight.
// Pipeline: a tick passes the input register, then the result register.
// Throughput: one tick per cycle unless m_tready stalls the result; the
// phase/slot/counter update between the two registers is combinational.
// Reset: phase returns to send, slot and wait counters clear, registers take
// their reset values, both stages empty.
// Stall: when m_tready is low the result holds; the input register still
// takes one more tick, after which s_tready drops until the result drains.
// Depends on lms_pkg, lms_cfg_regs and lms_step.
`default_nettype none

module lin_master_schedule_sequencer (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  // driver_status[1:0], driver_data[65:2], zero pad above
  input  wire  [lms_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  // send_valid[0], send_pid[8:1], send_enhanced[9], send_receive[10],
  // send_length[14:11], send_data[78:15], phase[81:79], slot[83:82],
  // received_valid[84], received_data[148:85], zero pad above
  output logic [lms_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [lms_pkg::CIDX_W-1:0]       cfg_index,
  input  wire  [lms_pkg::DATA_W-1:0]       cfg_data
);
  import lms_pkg::*;

  cfg_t    cfg;
  result_t step_res;
  result_t out_res;

  logic                in_valid;
  logic [STATUS_W-1:0] in_status;
  logic [DATA_W-1:0]   in_data;
  logic                out_load;
  logic                advance;

  lms_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Result register takes a new tick when empty or being drained
  assign out_load = !m_tvalid || m_tready;
  assign advance  = in_valid && out_load;
  assign s_tready = !in_valid || out_load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_status <= s_tdata[STATUS_W-1:0];
      in_data   <= s_tdata[STATUS_W +: DATA_W];
    end
  end

  lms_step u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .status  (in_status),
    .ddata   (in_data),
    .cfg     (cfg),
    .res     (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= step_res;
  end

  assign m_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_res};

  // A frame request always moves into a wait phase
  a_send_to_wait: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.send_valid |->
      (out_res.phase == PH_TX_WAIT || out_res.phase == PH_RX_WAIT))
    else $error("frame request without entering a wait phase");

  // Received bytes only come with receive success or receive timeout
  a_rx_phase: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.received_valid |->
      (out_res.phase == PH_RX_OK || out_res.phase == PH_RX_TIMEOUT))
    else $error("received data outside a receive phase");

  // A request and a reception never share one tick
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_res.send_valid && out_res.received_valid))
    else $error("send and receive reported in the same tick");

  // Transmit payload is zero for a receive frame
  a_rx_no_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.send_receive |-> out_res.send_data == '0)
    else $error("transmit payload on a receive frame");

  // Both stages empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && !in_valid)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
